>>> rtl/core/knapsack_01_best_load_top_macros.svh
// assertion macros shared by the knapsack best-load core
// used by kbl_front, kbl_queue and kbl_back; no other dependencies
`ifndef KNAPSACK_01_BEST_LOAD_TOP_MACROS_SVH
`define KNAPSACK_01_BEST_LOAD_TOP_MACROS_SVH

// condition holds on every clock outside reset
`define KBL_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the next
`define KBL_IMPLY_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/kbl_pkg.sv
// types and constants for the knapsack best-load core
// no dependencies; imported by every module of the core
package kbl_pkg;

  localparam int TableDepth = 64;
  localparam int ItemLimit  = 128;
  localparam int QueueDepth = 2;
  localparam int TblAw      = $clog2(TableDepth);
  localparam int SeenW      = 8;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam logic [5:0] CapReset = 6'd50;

  typedef struct packed {
    logic [15:0] item_value;
    logic [5:0]  item_weight;
    logic        last_item;
  } kbl_in_t;

  typedef struct packed {
    logic [23:0] best_value;
    logic [5:0]  best_weight;
    logic [7:0]  items_left;
    logic        overflow;
  } kbl_out_t;

  typedef struct packed {
    logic [15:0]      value;
    logic [5:0]       weight;
    logic             last;
    logic             sweep;
    logic [SeenW-1:0] seen;
    logic             dropped;
  } kbl_cmd_t;

  typedef struct packed {
    logic [23:0] value;
    logic [5:0]  weight;
    logic [7:0]  taken;
  } kbl_entry_t;

endpackage

>>> rtl/core/kbl_front.sv
// front end: accepts requests, counts items and marks drops past the item limit
// depends on kbl_pkg and knapsack_01_best_load_top_macros.svh
`include "knapsack_01_best_load_top_macros.svh"

module kbl_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  kbl_pkg::kbl_in_t in_item,
  input  logic             q_full,
  output logic             busy,
  output logic             push,
  output kbl_pkg::kbl_cmd_t cmd
);
  import kbl_pkg::*;

  logic [SeenW-1:0] seen_r, seen_nxt;
  logic             drop_r, drop_nxt;
  logic             room;

  assign busy = q_full;
  assign push = start && !q_full;
  assign room = (32'(seen_r) < ItemLimit);

  always_comb begin
    seen_nxt = seen_r;
    drop_nxt = drop_r;
    if (room) begin
      seen_nxt = seen_r + SeenW'(1);
    end else begin
      drop_nxt = 1'b1;
    end
    cmd.value   = in_item.item_value;
    cmd.weight  = in_item.item_weight;
    cmd.last    = in_item.last_item;
    cmd.sweep   = room;
    cmd.seen    = seen_nxt;
    cmd.dropped = drop_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      drop_r <= 1'b0;
    end else if (push) begin
      if (in_item.last_item) begin
        seen_r <= '0;
        drop_r <= 1'b0;
      end else begin
        seen_r <= seen_nxt;
        drop_r <= drop_nxt;
      end
    end
  end

  `KBL_CHECK(a_seen_bound, 32'(seen_r) <= ItemLimit, "item count past limit")
  `KBL_IMPLY_NEXT(a_last_clears, push && in_item.last_item, seen_r == '0 && !drop_r,
                  "set state not cleared after last item")

endmodule

>>> rtl/core/kbl_queue.sv
// short command queue between front and back
// depends on kbl_pkg and knapsack_01_best_load_top_macros.svh
`include "knapsack_01_best_load_top_macros.svh"

module kbl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  kbl_pkg::kbl_cmd_t push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output kbl_pkg::kbl_cmd_t head
);
  import kbl_pkg::*;

  localparam int CntW = $clog2(QueueDepth + 1);

  kbl_cmd_t         slot_r [QueueDepth];
  logic [QPtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0]  cnt_r;
  logic             do_push, do_pop;

  assign full      = (32'(cnt_r) == QueueDepth);
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rp_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  function automatic logic [QPtrW-1:0] bump(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    if (32'(p) == QueueDepth - 1) begin
      r = '0;
    end else begin
      r = p + QPtrW'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= bump(wp_r);
      end
      if (do_pop) begin
        rp_r <= bump(rp_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CntW'(1);
      end
    end
  end

  `KBL_CHECK(a_no_push_full, !(push && full), "push into full queue")
  `KBL_CHECK(a_cnt_bound, 32'(cnt_r) <= QueueDepth, "queue count out of range")

endmodule

>>> rtl/core/kbl_back.sv
// back end: table sweep engine with the dp table memory and result readout
// depends on kbl_pkg and knapsack_01_best_load_top_macros.svh
`include "knapsack_01_best_load_top_macros.svh"

module kbl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_vld,
  input  kbl_pkg::kbl_cmd_t cmd,
  input  logic [5:0]        cap,
  output logic              cmd_pop,
  output logic              out_valid,
  output kbl_pkg::kbl_out_t out_result
);
  import kbl_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SWEEP, S_DRAIN, S_READ, S_EMIT} state_t;

  state_t            state_r, state_nxt;
  kbl_cmd_t          cur_r, cur_nxt;
  logic [TblAw-1:0]  cnt_r, cnt_nxt;
  logic              p_vld_r, p_vld_nxt;
  logic              p_en_r, p_en_nxt;
  logic [TblAw-1:0]  p_addr_r, p_addr_nxt;
  logic              out_vld_r, out_vld_nxt;
  kbl_out_t          out_r, out_nxt;

  kbl_entry_t        mem [TableDepth];
  logic [TableDepth-1:0] vld_r;
  logic [TblAw-1:0]  rda_addr, rdb_addr, cap_idx;
  kbl_entry_t        rda_q, rdb_q;
  logic              rdav_q, rdbv_q;
  kbl_entry_t        a_ent, b_ent, w_ent;
  logic [24:0]       take_v;
  logic              wr, clr;

  assign out_valid  = out_vld_r;
  assign out_result = out_r;

  // table read-modify-write
  always_comb begin
    a_ent  = rdav_q ? rda_q : '0;
    b_ent  = rdbv_q ? rdb_q : '0;
    take_v = {1'b0, b_ent.value} + 25'(cur_r.value);
    wr     = p_vld_r && p_en_r && (take_v >= {1'b0, a_ent.value});
    w_ent.value  = take_v[23:0];
    w_ent.weight = b_ent.weight + cur_r.weight;
    w_ent.taken  = b_ent.taken + 8'd1;
  end

  always_comb begin
    if (32'(cap) > TableDepth - 1) begin
      cap_idx = TblAw'(TableDepth - 1);
    end else begin
      cap_idx = TblAw'(cap);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    cnt_nxt     = cnt_r;
    p_vld_nxt   = 1'b0;
    p_en_nxt    = 1'b0;
    p_addr_nxt  = cnt_r;
    out_vld_nxt = 1'b0;
    out_nxt     = out_r;
    cmd_pop     = 1'b0;
    clr         = 1'b0;
    rda_addr    = cnt_r;
    rdb_addr    = TblAw'(32'(cnt_r) - 32'(cur_r.weight));
    unique case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          cmd_pop = 1'b1;
          cur_nxt = cmd;
          if (cmd.sweep) begin
            cnt_nxt   = TblAw'(TableDepth - 1);
            state_nxt = S_SWEEP;
          end else if (cmd.last) begin
            state_nxt = S_READ;
          end
        end
      end
      S_SWEEP: begin
        p_vld_nxt = 1'b1;
        p_en_nxt  = (32'(cnt_r) >= 32'(cur_r.weight));
        if (cnt_r == TblAw'(1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r - TblAw'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = cur_r.last ? S_READ : S_IDLE;
      end
      S_READ: begin
        rda_addr  = cap_idx;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_vld_nxt         = 1'b1;
        out_nxt.best_value  = a_ent.value;
        out_nxt.best_weight = a_ent.weight;
        out_nxt.items_left  = cur_r.seen - a_ent.taken;
        out_nxt.overflow    = cur_r.dropped;
        clr                 = 1'b1;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      p_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      p_vld_r   <= p_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    cur_r    <= cur_nxt;
    cnt_r    <= cnt_nxt;
    p_en_r   <= p_en_nxt;
    p_addr_r <= p_addr_nxt;
    out_r    <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[p_addr_r] <= w_ent;
    end
    rda_q  <= mem[rda_addr];
    rdb_q  <= mem[rdb_addr];
    rdav_q <= vld_r[rda_addr];
    rdbv_q <= vld_r[rdb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (wr) begin
      vld_r[p_addr_r] <= 1'b1;
    end
  end

  `KBL_IMPLY_NEXT(a_strobe_one, out_vld_r, !out_vld_r, "result strobe held two cycles")
  `KBL_CHECK(a_no_wr_zero, !(wr && p_addr_r == '0), "write to capacity zero entry")
  `KBL_IMPLY_NEXT(a_read_emit, state_r == S_READ, state_r == S_EMIT, "readout skipped emit")

endmodule

>>> rtl/core/knapsack_01_best_load_top.sv
// 0/1 knapsack best-load core: front end, command queue, table sweep back end
// depends on kbl_pkg, kbl_front, kbl_queue and kbl_back
// a kept item holds the back end for dispatch, a sweep of entries 63 down to 1 and a drain;
// a last item adds the read and emit states, its result strobe registered from emit; the
// sweep writes through the single table write port, a new item is taken only in idle, and
// a dropped item skips the sweep; reset clears control, valid bits, counts, capacity 50
module knapsack_01_best_load_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  kbl_pkg::kbl_in_t  in_item,
  output logic              busy,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  output logic              out_valid,
  output kbl_pkg::kbl_out_t out_result
);
  import kbl_pkg::*;

  logic [5:0] capacity_r;
  logic       q_full, q_nempty, push, pop;
  kbl_cmd_t   f_cmd, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CapReset;
    end else if (cfg_we) begin
      capacity_r <= cfg_wdata;
    end
  end

  kbl_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .cmd     (f_cmd)
  );

  kbl_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (f_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_nempty),
    .head      (q_head)
  );

  kbl_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_vld    (q_nempty),
    .cmd        (q_head),
    .cap        (capacity_r),
    .cmd_pop    (pop),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule
